[rtl/gbp_pkg.sv]
// shared constants, types and tables for the gaussian beam profile pipeline
package gbp_pkg;

  // fixed point of the exponential and the quotients
  localparam int EXP_FRAC_BITS = 16;
  localparam int WBITS         = 30;

  // coordinate and product widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int NUM_W   = SQ_W + 1;
  localparam int DEN_W   = 2 * COORD_W + 1;

  // long division: capped integer part plus one extra fraction bit
  localparam int QCAP_LOG  = 6;
  localparam int DIV_FRAC  = EXP_FRAC_BITS + 1;
  localparam int QB_W      = QCAP_LOG + DIV_FRAC;
  localparam int QUO_W     = QB_W + 1;
  localparam int REM_W     = DEN_W + QCAP_LOG + 1;
  localparam int DIV_STEPS = 1 + QB_W;

  // exponential unit
  localparam int ARG_W        = QUO_W;
  localparam int EXP_W        = EXP_FRAC_BITS + 1;
  localparam int TAYLOR_TERMS = 24;
  localparam int N_LIMIT_LOG  = 5;
  localparam int N_STEPS      = (1 << N_LIMIT_LOG) - 1;
  localparam int RECIP_SH     = 35;
  localparam int RECIP_W      = 35;
  localparam int M1_W         = 29;
  localparam logic [M1_W-1:0] EXP_M1_Q30 = 29'd395007542;

  // amplitudes, result and configuration
  localparam int AMP_W   = 24;
  localparam int OUT_W   = 25;
  localparam int OUT_MAX = 16777215;
  localparam int OUT_MIN = -16777216;
  localparam int CFG_W   = 48;
  localparam int CFG_A_W = 3;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SINGLE_MODE   = 3'd0,
    CFG_BEAM_RADIUS   = 3'd1,
    CFG_SHIFT_XY      = 3'd2,
    CFG_AMPLITUDE_ONE = 3'd3,
    CFG_AMPLITUDE_TWO = 3'd4,
    CFG_SIGMAS_ONE    = 3'd5,
    CFG_SIGMAS_TWO    = 3'd6
  } cfg_reg_t;

  // ceil(2^35 / k), exact floor division for 30-bit dividends
  function automatic logic [RECIP_W-1:0] recip_q35(input logic [4:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      5'd2:    m = 35'd17179869184;
      5'd3:    m = 35'd11453246123;
      5'd4:    m = 35'd8589934592;
      5'd5:    m = 35'd6871947674;
      5'd6:    m = 35'd5726623062;
      5'd7:    m = 35'd4908534053;
      5'd8:    m = 35'd4294967296;
      5'd9:    m = 35'd3817748708;
      5'd10:   m = 35'd3435973837;
      5'd11:   m = 35'd3123612579;
      5'd12:   m = 35'd2863311531;
      5'd13:   m = 35'd2643056798;
      5'd14:   m = 35'd2454267027;
      5'd15:   m = 35'd2290649225;
      5'd16:   m = 35'd2147483648;
      5'd17:   m = 35'd2021161081;
      5'd18:   m = 35'd1908874354;
      5'd19:   m = 35'd1808407283;
      5'd20:   m = 35'd1717986919;
      5'd21:   m = 35'd1636178018;
      5'd22:   m = 35'd1561806290;
      5'd23:   m = 35'd1493901669;
      5'd24:   m = 35'd1431655766;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/gaussian_beam_profile_eval.sv]
// top level: gaussian beam density at a grid point, single or double profile
// throughput: one point per cycle while not stalled, every stage holds an independent item
// the whole pipeline stalls only when a result waits and the stage behind it is full
// rst (synchronous) clears valid bits and loads the register reset values
module gaussian_beam_profile_eval (
  input  logic                          clk,
  input  logic                          rst,
  // input point
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,     // x_coord [23:0], y_coord [47:24]
  // result
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,     // density [24:0], zero [31:25]
  // register writes
  input  logic                          cfg_wr_en,
  input  logic [gbp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [gbp_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int F     = gbp_pkg::EXP_FRAC_BITS;
  localparam int CW    = gbp_pkg::COORD_W;
  localparam int DW    = gbp_pkg::DIFF_W;
  localparam int SQW   = gbp_pkg::SQ_W;
  localparam int NW    = gbp_pkg::NUM_W;
  localparam int DENW  = gbp_pkg::DEN_W;
  localparam int QW    = gbp_pkg::QUO_W;
  localparam int AW    = gbp_pkg::ARG_W;
  localparam int EW    = gbp_pkg::EXP_W;
  localparam int AMPW  = gbp_pkg::AMP_W;
  localparam int OW    = gbp_pkg::OUT_W;
  localparam int PW    = AMPW + EW + 1;
  localparam int PSW   = PW + 1;
  localparam int SH_R  = (F >= 16) ? F - 16 : 0;
  localparam int SH_L  = (F < 16) ? 16 - F : 0;
  localparam logic signed [PSW-1:0] SAT_HI = PSW'(gbp_pkg::OUT_MAX);
  localparam logic signed [PSW-1:0] SAT_LO = PSW'(gbp_pkg::OUT_MIN);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic            single_mode;
  logic [CW-1:0]   beam_radius;
  logic [2*CW-1:0] shift_xy;
  logic [AMPW-1:0] amplitude_one;
  logic [AMPW-1:0] amplitude_two;
  logic [2*CW-1:0] sigmas_one;
  logic [2*CW-1:0] sigmas_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_mode   <= 1'b1;
      beam_radius   <= 24'd1000;
      shift_xy      <= '0;
      amplitude_one <= 24'd65536;
      amplitude_two <= '0;
      sigmas_one    <= {24'd1000, 24'd1000};
      sigmas_two    <= {24'd1000, 24'd1000};
    end else if (cfg_wr_en) begin
      unique case (gbp_pkg::cfg_reg_t'(cfg_addr))
        gbp_pkg::CFG_SINGLE_MODE:   single_mode   <= cfg_wr_data[0];
        gbp_pkg::CFG_BEAM_RADIUS:   beam_radius   <= cfg_wr_data[CW-1:0];
        gbp_pkg::CFG_SHIFT_XY:      shift_xy      <= cfg_wr_data[2*CW-1:0];
        gbp_pkg::CFG_AMPLITUDE_ONE: amplitude_one <= cfg_wr_data[AMPW-1:0];
        gbp_pkg::CFG_AMPLITUDE_TWO: amplitude_two <= cfg_wr_data[AMPW-1:0];
        gbp_pkg::CFG_SIGMAS_ONE:    sigmas_one    <= cfg_wr_data[2*CW-1:0];
        gbp_pkg::CFG_SIGMAS_TWO:    sigmas_two    <= cfg_wr_data[2*CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // divisors: squared sigmas, a zero sigma counts as one
  // the user must change the registers only while idle (not enforced here), so these settle before any point needs them
  // ---------------------------------------------------------------
  logic [CW-1:0]   r_nz, sx1_nz, sy1_nz, sx2_nz, sy2_nz;
  logic [2*CW-1:0] r_sq, sx1_sq, sy1_sq, sx2_sq, sy2_sq;
  logic [DENW-1:0] den0, den1, den2, den3;

  always_comb begin
    r_nz   = (beam_radius == '0) ? CW'(1) : beam_radius;
    sx1_nz = (sigmas_one[CW-1:0] == '0) ? CW'(1) : sigmas_one[CW-1:0];
    sy1_nz = (sigmas_one[2*CW-1:CW] == '0) ? CW'(1) : sigmas_one[2*CW-1:CW];
    sx2_nz = (sigmas_two[CW-1:0] == '0) ? CW'(1) : sigmas_two[CW-1:0];
    sy2_nz = (sigmas_two[2*CW-1:CW] == '0) ? CW'(1) : sigmas_two[2*CW-1:CW];
  end

  always_ff @(posedge clk) begin
    r_sq   <= r_nz * r_nz;
    sx1_sq <= sx1_nz * sx1_nz;
    sy1_sq <= sy1_nz * sy1_nz;
    sx2_sq <= sx2_nz * sx2_nz;
    sy2_sq <= sy2_nz * sy2_nz;
    // single mode divides by 2 r^2 in lane 0
    den0   <= single_mode ? {r_sq, 1'b0} : {1'b0, sx1_sq};
    den1   <= {1'b0, sy1_sq};
    den2   <= {1'b0, sx2_sq};
    den3   <= {1'b0, sy2_sq};
  end

  // ---------------------------------------------------------------
  // stall control: advance unless a waiting result blocks a full last stage
  // ---------------------------------------------------------------
  logic adv;
  logic out_load;
  logic last_valid;
  logic [OW-1:0] last_density;

  assign out_load = !m_tvalid || m_tready;
  assign adv      = out_load || !last_valid;
  assign s_tready = adv;

  // ---------------------------------------------------------------
  // front end: offsets, squares, numerators
  // ---------------------------------------------------------------
  logic                  f1_vld, f2_vld, f3_vld;
  logic signed [DW-1:0]  dx, dy;
  logic [SQW-1:0]        dx2, dy2;
  logic [NW-1:0]         num0;
  logic [SQW-1:0]        num_dx, num_dy;
  logic signed [2*DW-1:0] dx_sq, dy_sq;

  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= s_tvalid;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx     <= DW'($signed(s_tdata[CW-1:0])) - DW'($signed(shift_xy[CW-1:0]));
      dy     <= DW'($signed(s_tdata[2*CW-1:CW])) - DW'($signed(shift_xy[2*CW-1:CW]));
      dx2    <= dx_sq[SQW-1:0];
      dy2    <= dy_sq[SQW-1:0];
      num0   <= single_mode ? NW'(dx2) + NW'(dy2) : NW'(dx2);
      num_dx <= dx2;
      num_dy <= dy2;
    end
  end

  // ---------------------------------------------------------------
  // four divider lanes: x and y quotients of both terms
  // ---------------------------------------------------------------
  logic          d_vld;
  logic [QW-1:0] t0, t1, t2, t3;

  gbp_div u_div0 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f3_vld),
    .num(num0), .den(den0), .out_valid(d_vld), .quo(t0)
  );
  gbp_div u_div1 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f3_vld),
    .num(NW'(num_dy)), .den(den1), .out_valid(), .quo(t1)
  );
  gbp_div u_div2 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f3_vld),
    .num(NW'(num_dx)), .den(den2), .out_valid(), .quo(t2)
  );
  gbp_div u_div3 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f3_vld),
    .num(NW'(num_dy)), .den(den3), .out_valid(), .quo(t3)
  );

  // ---------------------------------------------------------------
  // exponents: halve the extra fraction bit away
  // ---------------------------------------------------------------
  logic          g_vld;
  logic [AW-1:0] arg0, arg1;
  logic [QW:0]   sum01, sum23;

  assign sum01 = single_mode ? {1'b0, t0} : {1'b0, t0} + {1'b0, t1};
  assign sum23 = {1'b0, t2} + {1'b0, t3};

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arg0 <= sum01[QW:1];
      arg1 <= sum23[QW:1];
    end
  end

  logic          e_vld;
  logic [EW-1:0] e0, e1;

  gbp_exp u_exp0 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(g_vld),
    .arg(arg0), .out_valid(e_vld), .value(e0)
  );
  gbp_exp u_exp1 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(g_vld),
    .arg(arg1), .out_valid(), .value(e1)
  );

  // ---------------------------------------------------------------
  // weighting, floor shift and saturation of both terms; single mode passes the first exponential
  // ---------------------------------------------------------------
  logic                 p_vld;
  logic signed [PW-1:0] prod1, prod2;
  logic [EW-1:0]        e_single;
  logic signed [PSW-1:0] psum, pfloor;
  logic [OW-1:0]        dens_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld      <= 1'b0;
      last_valid <= 1'b0;
    end else if (adv) begin
      p_vld      <= e_vld;
      last_valid <= p_vld;
    end
  end

  always_comb begin
    psum   = PSW'(prod1) + PSW'(prod2);
    pfloor = psum >>> F;
    if (single_mode) begin
      dens_next = OW'((OW'(e_single) >> SH_R) << SH_L);
    end else if (pfloor > SAT_HI) begin
      dens_next = OW'(SAT_HI);
    end else if (pfloor < SAT_LO) begin
      dens_next = OW'(SAT_LO);
    end else begin
      dens_next = pfloor[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1        <= $signed(amplitude_one) * $signed({1'b0, e0});
      prod2        <= $signed(amplitude_two) * $signed({1'b0, e1});
      e_single     <= e0;
      last_density <= dens_next;
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  logic [OW-1:0] density;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      density <= last_density;
    end
  end

  assign m_tdata = {(32 - OW)'(0), density};

endmodule

[rtl/gbp_div.sv]
// pipelined restoring divider, a cap check stage, then one quotient bit per stage, integer part capped
module gbp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gbp_pkg::NUM_W-1:0]   num,
  input  logic [gbp_pkg::DEN_W-1:0]   den,
  output logic                        out_valid,
  output logic [gbp_pkg::QUO_W-1:0]   quo
);

  localparam int STEPS = gbp_pkg::DIV_STEPS;
  localparam int REM_W = gbp_pkg::REM_W;
  localparam int QB_W  = gbp_pkg::QB_W;
  localparam int QCAP  = gbp_pkg::QCAP_LOG;

  logic              vld  [1:STEPS];
  logic              cap  [1:STEPS];
  logic [REM_W-1:0]  rem  [1:STEPS];
  logic [QB_W-1:0]   bits [1:STEPS];

  logic [REM_W-1:0] den_ext;
  assign den_ext = REM_W'(den);

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic             vld_cur;
    logic             cap_cur;
    logic [REM_W-1:0] rem_cur;
    logic [QB_W-1:0]  bits_cur;
    logic             cap_next;
    logic [REM_W-1:0] rem_next;
    logic [QB_W-1:0]  bits_next;

    if (s == 0) begin : g_src
      assign vld_cur  = in_valid;
      assign cap_cur  = 1'b0;
      assign rem_cur  = REM_W'(num);
      assign bits_cur = '0;
    end else begin : g_src
      assign vld_cur  = vld[s];
      assign cap_cur  = cap[s];
      assign rem_cur  = rem[s];
      assign bits_cur = bits[s];
    end

    if (s == 0) begin : g_op
      // quotient of 64 or more saturates
      always_comb begin
        cap_next  = rem_cur >= (den_ext << QCAP);
        rem_next  = rem_cur;
        bits_next = bits_cur;
      end
    end else if (s <= QCAP) begin : g_op
      // integer bits, divisor aligned
      logic [REM_W-1:0] trial;
      logic             ge;
      always_comb begin
        trial     = den_ext << (QCAP - s);
        ge        = rem_cur >= trial;
        cap_next  = cap_cur;
        rem_next  = ge ? rem_cur - trial : rem_cur;
        bits_next = {bits_cur[QB_W-2:0], ge};
      end
    end else begin : g_op
      // fraction bits
      logic [REM_W-1:0] sh;
      logic             ge;
      always_comb begin
        sh        = rem_cur << 1;
        ge        = sh >= den_ext;
        cap_next  = cap_cur;
        rem_next  = ge ? sh - den_ext : sh;
        bits_next = {bits_cur[QB_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cap[s+1]  <= cap_next;
        rem[s+1]  <= rem_next;
        bits[s+1] <= bits_next;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign quo = cap[STEPS] ? (gbp_pkg::QUO_W'(1) << QB_W) : {1'b0, bits[STEPS]};

endmodule

[rtl/gbp_exp.sv]
// pipelined exp(-a): taylor series of the fraction, then repeated e^-1 steps
module gbp_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gbp_pkg::ARG_W-1:0]   arg,
  output logic                        out_valid,
  output logic [gbp_pkg::EXP_W-1:0]   value
);

  localparam int F  = gbp_pkg::EXP_FRAC_BITS;
  localparam int W  = gbp_pkg::WBITS;
  localparam int K  = gbp_pkg::TAYLOR_TERMS;
  localparam int NS = gbp_pkg::N_STEPS;
  localparam int NL = gbp_pkg::N_LIMIT_LOG;
  localparam int RW = gbp_pkg::RECIP_W;
  localparam int RS = gbp_pkg::RECIP_SH;
  localparam int MW = gbp_pkg::M1_W;

  typedef struct packed {
    logic          zero;
    logic [NL-1:0] n;
    logic [F-1:0]  frac;
  } exp_ctl_t;

  // term stages (k = 1 is the entry stage)
  logic                b_vld  [1:K];
  exp_ctl_t            b_ctl  [1:K];
  logic [W-1:0]        b_term [1:K];
  logic signed [W+1:0] b_sum  [1:K];
  // product stages
  logic                a_vld  [2:K];
  exp_ctl_t            a_ctl  [2:K];
  logic [W-1:0]        a_prod [2:K];
  logic signed [W+1:0] a_sum  [2:K];
  // e^-1 stages (index 0 is the clamp stage)
  logic                m_vld  [0:NS];
  exp_ctl_t            m_ctl  [0:NS];
  logic [W:0]          m_v    [0:NS];

  logic [W-1:0] fw_in;
  exp_ctl_t     ctl_in;

  always_comb begin
    fw_in       = {arg[F-1:0], (W-F)'(0)};
    ctl_in.zero = arg[gbp_pkg::ARG_W-1:F+NL] != '0;
    ctl_in.n    = arg[F+NL-1:F];
    ctl_in.frac = arg[F-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld[1] <= 1'b0;
    end else if (en) begin
      b_vld[1] <= in_valid;
    end
  end

  // first term of the series is the fraction itself
  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl[1]  <= ctl_in;
      b_term[1] <= fw_in;
      b_sum[1]  <= $signed((W+2)'(1) << W) - $signed({2'b00, fw_in});
    end
  end

  for (genvar k = 2; k <= K; k++) begin : g_term
    logic [2*W-1:0]  p;
    logic [W+RW-1:0] pq;
    logic [W-1:0]    q;

    assign p  = b_term[k-1] * {b_ctl[k-1].frac, (W-F)'(0)};
    assign pq = a_prod[k] * gbp_pkg::recip_q35(5'(k));
    assign q  = pq[RS+W-1:RS];

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld[k] <= 1'b0;
        b_vld[k] <= 1'b0;
      end else if (en) begin
        a_vld[k] <= b_vld[k-1];
        b_vld[k] <= a_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_ctl[k]  <= b_ctl[k-1];
        a_prod[k] <= p[2*W-1:W];
        a_sum[k]  <= b_sum[k-1];
        b_ctl[k]  <= a_ctl[k];
        b_term[k] <= q;
        // odd terms subtract
        if ((k % 2) == 1) begin
          b_sum[k] <= a_sum[k] - $signed({2'b00, q});
        end else begin
          b_sum[k] <= a_sum[k] + $signed({2'b00, q});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld[0] <= 1'b0;
    end else if (en) begin
      m_vld[0] <= b_vld[K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ctl[0] <= b_ctl[K];
      m_v[0]   <= b_sum[K][W+1] ? '0 : b_sum[K][W:0];
    end
  end

  // one e^-1 multiply per stage while the integer part lasts
  for (genvar i = 0; i < NS; i++) begin : g_int
    logic [W+MW:0] pm;
    assign pm = m_v[i] * gbp_pkg::EXP_M1_Q30;

    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[i+1] <= 1'b0;
      end else if (en) begin
        m_vld[i+1] <= m_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_ctl[i+1] <= m_ctl[i];
        m_v[i+1]   <= (m_ctl[i].n > NL'(i)) ? (W+1)'(pm >> W) : m_v[i];
      end
    end
  end

  assign out_valid = m_vld[NS];
  assign value = m_ctl[NS].zero ? '0 : gbp_pkg::EXP_W'(m_v[NS] >> (W - F));

endmodule
